FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHECK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: implication");

// Next-cycle implication, disabled during reset.
`define CHECK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

FILE: rtl/core/rotarc_pkg.sv
package rotarc_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int LIM  = (ONE < 32767) ? ONE : 32767;

  localparam int IW   = 16;               // vector / quaternion field width
  localparam int QWW  = 15;               // quat_w width
  localparam int PW   = 2 * IW;           // product width
  localparam int CW   = PW + 1;           // cross component width
  localparam int DOTW = PW + 2;           // dot sum width
  localparam int DW   = FRAC_BITS + 2;    // clamped dot width
  localparam int SQW  = 2 * FRAC_BITS + 3; // sqrt radicand width
  localparam int SB   = FRAC_BITS + 2;    // sqrt result width
  localparam int SQ_ITER = (SQW + 1) / 2;
  localparam int SQ_ST   = (SQ_ITER + 1) / 2;
  localparam int QB   = 16;               // quotient bits before saturation
  localparam int DV_ST = QB / 2;
  localparam int MW   = CW + 1;           // rounded numerator width

  localparam logic signed [DOTW-1:0] LIM_D  = DOTW'(LIM);
  localparam logic signed [DOTW-1:0] ONE_D  = DOTW'(ONE);
  localparam logic signed [DOTW-1:0] HALF_D = DOTW'(ONE / 2);

  typedef struct packed {
    logic [SB:0]   rem;
    logic [QB-1:0] q;
  } lane_div_t;

  typedef struct packed {
    logic [SQW-1:0] x;
    logic [SQW:0]   r;
  } sq_t;

  typedef struct packed {
    logic [8:0][PW-1:0]  p;
    logic [2:0][CW-1:0]  c;
    logic [DOTW-1:0]     dot;
    logic [DW-1:0]       d;
    logic [IW-1:0]       dout;
    logic [2:0][IW-1:0]  dq;
    sq_t                 sq;
    logic [SB-1:0]       s;
    logic [QWW-1:0]      qw;
    logic [2:0]          neg;
    logic [2:0]          ovf;
    logic [2:0][QB-1:0]  ml;
    lane_div_t [2:0]     dv;
    logic [2:0][IW-1:0]  quat;
  } stage_t;

  // Shift right by FRAC_BITS, round half away from zero.
  function automatic logic signed [DOTW-1:0] rnd_shr(input logic signed [DOTW-1:0] v);
    logic signed [DOTW-1:0] m;
    m = v[DOTW-1] ? -v : v;
    m = (m + HALF_D) >>> FRAC_BITS;
    return v[DOTW-1] ? -m : m;
  endfunction

  function automatic logic signed [IW-1:0] sat_lim(input logic signed [DOTW-1:0] v);
    logic signed [DOTW-1:0] t;
    t = (v > LIM_D) ? LIM_D : ((v < -LIM_D) ? -LIM_D : v);
    return t[IW-1:0];
  endfunction

  // One digit of the integer square root; step k counts from the top pair.
  function automatic sq_t sq_step(input sq_t cur, input int k);
    sq_t o;
    logic [SQW:0] b;
    logic [SQW:0] t;
    o = cur;
    b = '0;
    t = '0;
    if (k < SQ_ITER) begin
      b = (SQW + 1)'(1) << (SQW - 1 - 2 * k);
      t = cur.r + b;
      if ({1'b0, cur.x} >= t) begin
        o.x = cur.x - t[SQW-1:0];
        o.r = (cur.r >> 1) + b;
      end else begin
        o.r = cur.r >> 1;
      end
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/rotarc_if.sv
// Input word: one pair of vectors.
interface rotarc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] first_z;
  logic signed [15:0] second_x;
  logic signed [15:0] second_y;
  logic signed [15:0] second_z;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                output ready);
endinterface

// Result word: quaternion and clamped dot.
interface rotarc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic        [14:0] quat_w;
  logic signed [15:0] dot_clamped;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, dot_clamped, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, dot_clamped, output ready);
endinterface

FILE: rtl/core/rotarc_div_step.sv
// Two restoring-division steps for the three axis lanes.
module rotarc_div_step (
  input  rotarc_pkg::lane_div_t [2:0]     din,
  input  logic [2:0][1:0]                 bits,
  input  logic [rotarc_pkg::SB-1:0]       s,
  output rotarc_pkg::lane_div_t [2:0]     dout
);
  import rotarc_pkg::*;

  always_comb begin
    lane_div_t    cur;
    logic [SB+1:0] t;
    for (int i = 0; i < 3; i++) begin
      cur = din[i];
      for (int k = 1; k >= 0; k--) begin
        t = {cur.rem, bits[i][k]};
        if (t >= {2'b00, s}) begin
          t = t - {2'b00, s};
          cur.q = {cur.q[QB-2:0], 1'b1};
        end else begin
          cur.q = {cur.q[QB-2:0], 1'b0};
        end
        cur.rem = t[SB:0];
      end
      dout[i] = cur;
    end
  end

endmodule

FILE: rtl/core/rotation_arc_quaternion.sv
// Shortest-arc rotation quaternion.
// vec (sink): one word holds two Q1.14 vectors, first and second.
// res (source): one word holds the quaternion (quat_x/y/z, quat_w) that
//   rotates first onto second, plus the clamped dot product.
// Both channels use valid/ready; a word moves when both are high.
// Throughput: one word per cycle when res is not stalled. The 21 register
//   stages are: multiply, sum, round/clamp, 8 square-root stages (two
//   digits each), finish, 8 divide stages (two quotient bits each),
//   saturate.
// Opposite vectors give w = 0 and the rounded cross product as axis.
// Reset (rst, synchronous) empties the pipeline; no result is pending.
// When res stalls, words pile up stage by stage; vec.ready drops only
//   once every stage holds a word. Nothing is lost or repeated.
`include "assert_macros.svh"

module rotation_arc_quaternion (
  input logic clk,
  input logic rst,
  rotarc_in_if.sink    vec,
  rotarc_out_if.source res
);
  import rotarc_pkg::*;

  localparam int S_RND = 2;
  localparam int S_SQ0 = 3;
  localparam int S_FIN = S_SQ0 + SQ_ST;
  localparam int S_DV0 = S_FIN + 1;
  localparam int S_OUT = S_DV0 + DV_ST;
  localparam int NS    = S_OUT + 1;

  stage_t        st [NS];
  stage_t        nx [NS];
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] vin;

  function automatic logic [PW-1:0] mul(input logic signed [IW-1:0] a,
                                        input logic signed [IW-1:0] b);
    return PW'(PW'(a) * PW'(b));
  endfunction

  // Per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[NS-1] = !v[NS-1] || res.ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v[i] || en[i+1];
    vin[0] = vec.valid;
    for (int i = 1; i < NS; i++) vin[i] = v[i-1];
  end

  assign vec.ready = en[0];

  // Stage 0: products
  always_comb begin
    nx[0] = '0;
    nx[0].p[0] = mul(vec.first_y, vec.second_z);
    nx[0].p[1] = mul(vec.first_z, vec.second_y);
    nx[0].p[2] = mul(vec.first_z, vec.second_x);
    nx[0].p[3] = mul(vec.first_x, vec.second_z);
    nx[0].p[4] = mul(vec.first_x, vec.second_y);
    nx[0].p[5] = mul(vec.first_y, vec.second_x);
    nx[0].p[6] = mul(vec.first_x, vec.second_x);
    nx[0].p[7] = mul(vec.first_y, vec.second_y);
    nx[0].p[8] = mul(vec.first_z, vec.second_z);
  end

  // Stage 1: cross and dot sums
  always_comb begin
    nx[1] = st[0];
    for (int i = 0; i < 3; i++) begin
      nx[1].c[i] = CW'($signed(st[0].p[2*i])) - CW'($signed(st[0].p[2*i+1]));
    end
    nx[1].dot = DOTW'($signed(st[0].p[6])) + DOTW'($signed(st[0].p[7]))
              + DOTW'($signed(st[0].p[8]));
  end

  // Stage 2: round and clamp dot, degenerate-axis results
  always_comb begin
    logic signed [DOTW-1:0] dr;
    nx[S_RND] = st[S_RND-1];
    dr = rnd_shr($signed(st[S_RND-1].dot));
    if (dr > ONE_D) dr = ONE_D;
    if (dr < -ONE_D) dr = -ONE_D;
    nx[S_RND].d    = dr[DW-1:0];
    nx[S_RND].dout = sat_lim(dr);
    for (int i = 0; i < 3; i++) begin
      nx[S_RND].dq[i] = sat_lim(rnd_shr(DOTW'($signed(st[S_RND-1].c[i]))));
    end
  end

  // Square root of 2(ONE + d) * ONE, two digits per stage
  for (genvar j = 0; j < SQ_ST; j++) begin : g_sq
    always_comb begin
      sq_t cur;
      nx[S_SQ0+j] = st[S_SQ0+j-1];
      cur = st[S_SQ0+j-1].sq;
      if (j == 0) begin
        cur.x = SQW'(ONE_D + DOTW'($signed(st[S_SQ0+j-1].d))) << (FRAC_BITS + 1);
        cur.r = '0;
      end
      cur = sq_step(cur, 2 * j);
      cur = sq_step(cur, 2 * j + 1);
      nx[S_SQ0+j].sq = cur;
    end
  end

  // Finish: rounded s, w part, rounded numerators and overflow check
  always_comb begin
    logic [SB-1:0]          s;
    logic [SB:0]            wt;
    logic signed [CW-1:0]   cs;
    logic [CW-1:0]          mag;
    logic [MW-1:0]          m;
    logic [MW-QB-1:0]       hi;
    nx[S_FIN] = st[S_FIN-1];
    s = SB'(st[S_FIN-1].sq.r + (SQW + 1)'({1'b0, st[S_FIN-1].sq.x} > st[S_FIN-1].sq.r));
    nx[S_FIN].s = s;
    wt = ((SB + 1)'(s) + (SB + 1)'(1)) >> 1;
    nx[S_FIN].qw = (wt > (SB + 1)'(LIM)) ? QWW'(LIM) : QWW'(wt);
    for (int i = 0; i < 3; i++) begin
      cs  = $signed(st[S_FIN-1].c[i]);
      mag = cs[CW-1] ? CW'(-cs) : CW'(cs);
      m   = MW'(mag) + MW'(s >> 1);
      hi  = m[MW-1:QB];
      nx[S_FIN].neg[i]    = cs[CW-1];
      nx[S_FIN].ml[i]     = m[QB-1:0];
      nx[S_FIN].ovf[i]    = hi >= (MW - QB)'(s);
      nx[S_FIN].dv[i].rem = hi[SB:0];
      nx[S_FIN].dv[i].q   = '0;
    end
  end

  // Division, two quotient bits per stage
  for (genvar j = 0; j < DV_ST; j++) begin : g_dv
    logic [2:0][1:0] bits;
    lane_div_t [2:0] dres;

    always_comb begin
      for (int i = 0; i < 3; i++) bits[i] = st[S_DV0+j-1].ml[i][QB-1 -: 2];
    end

    rotarc_div_step u_step (
      .din  (st[S_DV0+j-1].dv),
      .bits (bits),
      .s    (st[S_DV0+j-1].s),
      .dout (dres)
    );

    always_comb begin
      nx[S_DV0+j] = st[S_DV0+j-1];
      nx[S_DV0+j].dv = dres;
      for (int i = 0; i < 3; i++) nx[S_DV0+j].ml[i] = st[S_DV0+j-1].ml[i] << 2;
    end
  end

  // Output: saturate, sign, degenerate select
  always_comb begin
    logic [QB-1:0]        qm;
    logic signed [IW-1:0] qs;
    nx[S_OUT] = st[S_OUT-1];
    for (int i = 0; i < 3; i++) begin
      qm = (st[S_OUT-1].ovf[i] || st[S_OUT-1].dv[i].q > QB'(LIM))
         ? QB'(LIM) : st[S_OUT-1].dv[i].q;
      qs = st[S_OUT-1].neg[i] ? -$signed(IW'(qm)) : $signed(IW'(qm));
      nx[S_OUT].quat[i] = (st[S_OUT-1].s == '0) ? st[S_OUT-1].dq[i] : qs;
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= vin[i];
      end
      if (en[i] && vin[i]) st[i] <= nx[i];
    end
  end

  assign res.valid       = v[NS-1];
  assign res.quat_x      = st[NS-1].quat[0];
  assign res.quat_y      = st[NS-1].quat[1];
  assign res.quat_z      = st[NS-1].quat[2];
  assign res.quat_w      = st[NS-1].qw;
  assign res.dot_clamped = st[NS-1].dout;

  // An empty last stage means the whole pipe can move
  `CHECK_IMPLY(a_ready_when_drained, clk, rst, !v[NS-1], vec.ready)
  // Zero scalar part only for opposite vectors
  `CHECK_IMPLY(a_w_zero_opposite, clk, rst, res.valid && res.quat_w == '0,
               res.dot_clamped == -IW'(LIM))
  // Parallel vectors give the full scalar part
  `CHECK_IMPLY(a_w_full_parallel, clk, rst, res.valid && res.dot_clamped == IW'(ONE),
               res.quat_w == QWW'(LIM))

endmodule

FILE: dv/rotarc_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side copies of the channel interfaces are not needed: the RTL's
// interfaces are used directly. This file carries the word types only.
package rotarc_tb_pkg;
  typedef struct packed {
    logic signed [15:0] ax, ay, az, bx, by, bz;
  } pair_word_t;

  typedef struct packed {
    logic signed [15:0] qx, qy, qz;
    logic        [14:0] qw;
    logic signed [15:0] dot;
  } quat_word_t;
endpackage

FILE: dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import rotarc_pkg::*;
  import rotarc_tb_pkg::*;

  logic clk;
  logic rst;
  rotarc_in_if  vec();
  rotarc_out_if res();

  rotation_arc_quaternion u_dut (.clk(clk), .rst(rst), .vec(vec), .res(res));

  pair_word_t pending_pairs[$];
  quat_word_t expected_quats[$];
  int         error_count;
  bit         stim_done;
  int         long_hold;
  int         hold_cnt;
  bit         drain_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round to nearest, ties away from zero, by 2^sh.
  function automatic longint shift_round(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint divide_round(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic longint root_round(longint x);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= x) r++;
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Expected quaternion and clamped dot for one vector pair.
  function automatic quat_word_t arc_quat(pair_word_t p);
    quat_word_t q;
    longint ax, ay, az, bx, by, bz, cx, cy, cz, d, s, one, lim;
    one = 64'sd1 <<< FRAC_BITS;
    lim = (one < 32767) ? one : 32767;
    ax = p.ax; ay = p.ay; az = p.az; bx = p.bx; by = p.by; bz = p.bz;
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    d = clip(shift_round(ax * bx + ay * by + az * bz, FRAC_BITS), -one, one);
    s = root_round((2 * (one + d)) <<< FRAC_BITS);
    if (s == 0) begin
      cx = shift_round(cx, FRAC_BITS);
      cy = shift_round(cy, FRAC_BITS);
      cz = shift_round(cz, FRAC_BITS);
      q.qw = '0;
    end else begin
      cx = divide_round(cx, s);
      cy = divide_round(cy, s);
      cz = divide_round(cz, s);
      q.qw = 15'(clip((s + 1) >>> 1, 0, lim));
    end
    q.qx = 16'(clip(cx, -lim, lim));
    q.qy = 16'(clip(cy, -lim, lim));
    q.qz = 16'(clip(cz, -lim, lim));
    q.dot = 16'(clip(d, -lim, lim));
    return q;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 32768) - 16384);
      default: return 16'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  // Random pair: mostly one large and two small components per vector.
  function automatic pair_word_t rand_pair();
    pair_word_t p;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      p = {rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0),
           rand_comp(0)};
    end else begin
      p.ax = rand_comp(1); p.ay = rand_comp(2); p.az = rand_comp(2);
      case ($urandom_range(0, 3))
        0: begin p.bx = -p.ax; p.by = -p.ay; p.bz = -p.az; end
        1: begin p.bx = p.ax; p.by = p.ay; p.bz = p.az; end
        default: begin p.bx = rand_comp(2); p.by = rand_comp(1); p.bz = rand_comp(2); end
      endcase
    end
    return p;
  endfunction

  // Stimulus: directed corners, then random pairs with a drain pause.
  initial begin
    pair_word_t p;
    logic signed [15:0] vals[6];
    vals = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd32767, -16'sd32768, 16'sd1};
    error_count = 0;
    stim_done = 0;
    drain_req = 0;
    pending_pairs.push_back('{16384, 0, 0, 16384, 0, 0});
    pending_pairs.push_back('{16384, 0, 0, -16384, 0, 0});
    pending_pairs.push_back('{16384, 0, 0, 0, 16384, 0});
    pending_pairs.push_back('{0, 16384, 0, 0, 0, -16384});
    pending_pairs.push_back('{0, 0, -16384, 16384, 0, 0});
    pending_pairs.push_back('{-32768, -32768, -32768, 32767, 32767, 32767});
    pending_pairs.push_back('{-32768, -32768, -32768, -32768, -32768, -32768});
    pending_pairs.push_back('{32767, -32768, 32767, -32768, 32767, -32768});
    pending_pairs.push_back('{11585, 11585, 0, -11585, -11585, 0});
    pending_pairs.push_back('{11585, 0, 11585, 0, 11585, 11585});
    pending_pairs.push_back('{0, 0, 0, 0, 0, 0});
    pending_pairs.push_back('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
    for (int i = 0; i < 12; i++) begin
      p = {vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)],
           vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)]};
      pending_pairs.push_back(p);
    end
    for (int i = 0; i < 1600; i++) begin
      pending_pairs.push_back(rand_pair());
      if (i == 800) begin
        wait (pending_pairs.size() == 0 && !vec.valid);
        drain_req = 1;
        wait (expected_quats.size() == 0);
        drain_req = 0;
      end
    end
    wait (pending_pairs.size() == 0 && !vec.valid);
    stim_done = 1;
  end

  // Driver: offers queued pairs with random gaps.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      vec.valid <= 1'b0;
      {vec.first_x, vec.first_y, vec.first_z} <= '0;
      {vec.second_x, vec.second_y, vec.second_z} <= '0;
      send_gap <= 0;
    end else begin
      if (vec.valid && vec.ready) expected_quats.push_back(arc_quat(
        {vec.first_x, vec.first_y, vec.first_z, vec.second_x, vec.second_y, vec.second_z}));
      if (!vec.valid || vec.ready) begin
        if (send_gap > 0 || pending_pairs.size() == 0 || drain_req) begin
          vec.valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          pair_word_t p;
          p = pending_pairs.pop_front();
          vec.valid <= 1'b1;
          {vec.first_x, vec.first_y, vec.first_z} <= {p.ax, p.ay, p.az};
          {vec.second_x, vec.second_y, vec.second_z} <= {p.bx, p.by, p.bz};
          send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 0;
      hold_cnt <= 0;
    end else if (long_hold == 0 && pending_pairs.size() < 600 &&
                 pending_pairs.size() > 500) begin
      long_hold <= 1;
      hold_cnt <= 80;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: random stalls, field-by-field compare.
  int recv_gap;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_quats.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          quat_word_t e;
          e = expected_quats.pop_front();
          if (res.quat_x !== e.qx) report("quat_x", res.quat_x, e.qx);
          if (res.quat_y !== e.qy) report("quat_y", res.quat_y, e.qy);
          if (res.quat_z !== e.qz) report("quat_z", res.quat_z, e.qz);
          if (res.quat_w !== e.qw) report("quat_w", res.quat_w, e.qw);
          if (res.dot_clamped !== e.dot) report("dot_clamped", res.dot_clamped, e.dot);
        end
      end
      if (hold_cnt > 0) begin
        res.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res.ready <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        recv_gap <= $urandom_range(0, 5);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Reset and end of run.
  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    wait (expected_quats.size() == 0);
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_quats.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
